@@ rtl/core/zone_file_tokenizer_top_macros.svh @@
// Assertion macros for the zone file tokenizer.
// Used by zone_file_tokenizer_top; expects clk and rst_n in scope.
`ifndef ZONE_FILE_TOKENIZER_TOP_MACROS_SVH
`define ZONE_FILE_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ZFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define ZFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/zft_pkg.sv @@
// Types and constants for the zone file tokenizer.
// No dependencies; imported by zone_file_tokenizer_top.
`timescale 1ns / 1ps

package zft_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Deepest parenthesis nesting the depth counter reaches
  localparam int unsigned MAX_DEPTH = 15;
  localparam logic [3:0]  DEPTH_CAP = (MAX_DEPTH > 15) ? 4'd15 : 4'(MAX_DEPTH);

  localparam logic [7:0] TOK_MAX = 8'd255;

  // Error codes
  localparam logic [2:0] ERR_OK             = 3'd0;
  localparam logic [2:0] ERR_NL_IN_STRING   = 3'd1;
  localparam logic [2:0] ERR_STRAY_CLOSE    = 3'd2;
  localparam logic [2:0] ERR_DEPTH_OVERFLOW = 3'd3;
  localparam logic [2:0] ERR_EOF_OPEN       = 3'd4;

  // Lexer state carried from byte to byte
  typedef struct packed {
    logic       in_token;
    logic       in_quoted;
    logic       escape_pending;
    logic       in_comment;
    logic [3:0] nesting_depth;
    logic [7:0] tokens_in_record;
  } lex_state_t;

  function automatic logic is_nl(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

@@ rtl/core/zone_file_tokenizer_top.sv @@
// Zone file tokenizer: tags each byte of a zone file as token content, delimiter or skip.
// Result is registered, valid in the cycle after input transfer. Throughput: 1 byte per
// cycle while out_stall is low, set by the single lexer state update each byte makes.
// The output register frees itself in the same cycle its result is taken.
// Reset (rst_n low, synchronous) clears the lexer state and the output valid.
// Depends on zft_pkg and zone_file_tokenizer_top_macros.svh.
`timescale 1ns / 1ps

`include "zone_file_tokenizer_top_macros.svh"

module zone_file_tokenizer_top
  import zft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic       out_is_content,
  output logic       out_token_start,
  output logic       out_token_closed,
  output logic [7:0] out_token_index,
  output logic       out_record_end,
  output logic [3:0] out_paren_depth,
  output logic [2:0] out_error_code
);

  lex_state_t st_r, st_nxt;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       content_r, start_r, closed_r, recend_r;
  logic [7:0] idx_r;
  logic [3:0] depth_r;
  logic [2:0] err_r;

  logic       content, start, closed, recend, fresh;
  logic [7:0] idx;
  logic [3:0] depth_out;
  logic [2:0] err;
  logic       in_xfer;

  // Take a byte whenever the output register is empty or being drained
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // Lexer step for one byte
  always_comb begin
    st_nxt    = st_r;
    content   = 1'b0;
    start     = 1'b0;
    closed    = 1'b0;
    recend    = 1'b0;
    fresh     = 1'b0;
    idx       = '0;
    err       = ERR_OK;

    if (st_r.in_comment) begin
      if (is_nl(in_byte_in)) begin
        st_nxt.in_comment = 1'b0;
        fresh             = 1'b1;
      end
    end else if (st_r.in_quoted) begin
      if (is_nl(in_byte_in)) begin
        err    = ERR_NL_IN_STRING;
        closed = 1'b1;
        idx    = st_r.tokens_in_record;
        fresh  = 1'b1;
      end else begin
        content = 1'b1;
        idx     = st_r.tokens_in_record;
        if (st_r.escape_pending) begin
          st_nxt.escape_pending = 1'b0;
        end else if (in_byte_in == CH_BSLASH) begin
          st_nxt.escape_pending = 1'b1;
        end else if (in_byte_in == CH_QUOTE) begin
          closed = 1'b1;
        end
      end
    end else if (st_r.in_token) begin
      idx = st_r.tokens_in_record;
      if (is_blank(in_byte_in) || is_nl(in_byte_in) || in_byte_in == CH_SEMI ||
          in_byte_in == CH_QUOTE || in_byte_in == CH_LPAREN ||
          in_byte_in == CH_RPAREN) begin
        closed = 1'b1;
        fresh  = 1'b1;
      end else begin
        content = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    // Close the open token and count it
    if (closed) begin
      st_nxt.in_token       = 1'b0;
      st_nxt.in_quoted      = 1'b0;
      st_nxt.escape_pending = 1'b0;
      if (st_nxt.tokens_in_record != TOK_MAX) begin
        st_nxt.tokens_in_record = st_nxt.tokens_in_record + 8'd1;
      end
    end

    // Classify a byte seen outside any token or comment
    if (fresh) begin
      if (is_blank(in_byte_in)) begin
        st_nxt.in_comment = st_nxt.in_comment;
      end else if (is_nl(in_byte_in)) begin
        if (st_nxt.nesting_depth == '0 && st_nxt.tokens_in_record != '0) begin
          recend                  = 1'b1;
          st_nxt.tokens_in_record = '0;
        end
      end else if (in_byte_in == CH_SEMI) begin
        st_nxt.in_comment = 1'b1;
      end else if (in_byte_in == CH_LPAREN) begin
        if (st_nxt.nesting_depth >= DEPTH_CAP) begin
          err = ERR_DEPTH_OVERFLOW;
        end else begin
          st_nxt.nesting_depth = st_nxt.nesting_depth + 4'd1;
        end
      end else if (in_byte_in == CH_RPAREN) begin
        if (st_nxt.nesting_depth == '0) begin
          err = ERR_STRAY_CLOSE;
        end else begin
          st_nxt.nesting_depth = st_nxt.nesting_depth - 4'd1;
        end
      end else begin
        content               = 1'b1;
        start                 = 1'b1;
        st_nxt.in_token       = 1'b1;
        st_nxt.in_quoted      = (in_byte_in == CH_QUOTE);
        st_nxt.escape_pending = 1'b0;
        idx                   = st_nxt.tokens_in_record;
      end
    end

    depth_out = st_nxt.nesting_depth;

    // End of file: close what is open, report, then drop all state
    if (in_last_byte) begin
      if (st_nxt.in_token) begin
        if (st_nxt.in_quoted && err == ERR_OK) begin
          err = ERR_EOF_OPEN;
        end
        closed = 1'b1;
        idx    = st_nxt.tokens_in_record;
        if (st_nxt.tokens_in_record != TOK_MAX) begin
          st_nxt.tokens_in_record = st_nxt.tokens_in_record + 8'd1;
        end
      end
      if (st_nxt.nesting_depth != '0 && err == ERR_OK) begin
        err = ERR_EOF_OPEN;
      end
      if (st_nxt.tokens_in_record != '0) begin
        recend = 1'b1;
      end
      st_nxt = '0;
    end
  end

  // Advance lexer state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Hold output valid until the result transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load result payload on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r    <= in_byte_in;
      content_r <= content;
      start_r   <= start;
      closed_r  <= closed;
      idx_r     <= idx;
      recend_r  <= recend;
      depth_r   <= depth_out;
      err_r     <= err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = byte_r;
  assign out_is_content   = content_r;
  assign out_token_start  = start_r;
  assign out_token_closed = closed_r;
  assign out_token_index  = idx_r;
  assign out_record_end   = recend_r;
  assign out_paren_depth  = depth_r;
  assign out_error_code   = err_r;

  // Checks on lexer state and results
  `ZFT_ASSERT_NOW(a_quote_in_token, st_r.in_quoted, st_r.in_token,
                  "quoted state outside a token")
  `ZFT_ASSERT_NOW(a_escape_in_quote, st_r.escape_pending, st_r.in_quoted,
                  "escape pending outside a quoted token")
  `ZFT_ASSERT_NEXT(a_eof_clears, in_xfer && in_last_byte, st_r == '0,
                   "lexer state not cleared after last byte")
  `ZFT_ASSERT_NOW(a_start_is_content, out_valid_r && start_r, content_r,
                  "token start on a non-content byte")
  `ZFT_ASSERT_NOW(a_stray_close_depth, out_valid_r && err_r == ERR_STRAY_CLOSE,
                  depth_r == '0, "stray close with nonzero depth")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for zone_file_tokenizer_top: predicts the tag of every byte
// transfer and compares it with the result channel. Depends on zft_pkg and the RTL.
`timescale 1ns / 1ps

import zft_pkg::*;

// One result transfer, field for field
typedef struct packed {
  logic [7:0] byte_out;
  logic       is_content;
  logic       token_start;
  logic       token_closed;
  logic [7:0] token_index;
  logic       record_end;
  logic [3:0] paren_depth;
  logic [2:0] error_code;
} byte_tag_t;

function automatic logic blank_char(input logic [7:0] c);
  return (c == CH_SPACE) || (c == CH_TAB);
endfunction

function automatic logic line_break(input logic [7:0] c);
  return (c == CH_CR) || (c == CH_LF);
endfunction

// Bytes that end an unquoted word
function automatic logic word_break(input logic [7:0] c);
  return blank_char(c) || line_break(c) || (c == CH_SEMI) || (c == CH_QUOTE) ||
         (c == CH_LPAREN) || (c == CH_RPAREN);
endfunction

function automatic string show_tag(input byte_tag_t t);
  return $sformatf({"byte %02h content %0b start %0b closed %0b index %0d",
                    " rec_end %0b depth %0d err %0d"},
                   t.byte_out, t.is_content, t.token_start, t.token_closed, t.token_index,
                   t.record_end, t.paren_depth, t.error_code);
endfunction

class tag_scoreboard;
  lex_state_t  lex;
  byte_tag_t   pending_tags[$];
  int unsigned tag_errors;

  function new();
    lex = '0;
    tag_errors = 0;
  endfunction

  // Work out the tag of one byte and advance the lexer state
  function byte_tag_t tag_byte(input logic [7:0] c, input logic last);
    byte_tag_t t;
    logic      fresh;
    t = '0;
    t.byte_out = c;
    fresh = 1'b0;

    // Continue whatever the previous byte left open
    if (lex.in_comment) begin
      if (line_break(c)) begin
        lex.in_comment = 1'b0;
        fresh = 1'b1;
      end
    end else if (lex.in_quoted) begin
      t.token_index = lex.tokens_in_record;
      if (line_break(c)) begin
        t.error_code = ERR_NL_IN_STRING;
        t.token_closed = 1'b1;
        fresh = 1'b1;
      end else begin
        t.is_content = 1'b1;
        if (lex.escape_pending) lex.escape_pending = 1'b0;
        else if (c == CH_BSLASH) lex.escape_pending = 1'b1;
        else if (c == CH_QUOTE) t.token_closed = 1'b1;
      end
    end else if (lex.in_token) begin
      t.token_index = lex.tokens_in_record;
      if (word_break(c)) begin
        t.token_closed = 1'b1;
        fresh = 1'b1;
      end else begin
        t.is_content = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (t.token_closed) begin
      lex.in_token = 1'b0;
      lex.in_quoted = 1'b0;
      lex.escape_pending = 1'b0;
      if (lex.tokens_in_record != TOK_MAX) lex.tokens_in_record++;
    end

    // Classify a byte that is not part of an open token or comment
    if (fresh) begin
      if (line_break(c)) begin
        if (lex.nesting_depth == 0 && lex.tokens_in_record != 0) begin
          t.record_end = 1'b1;
          lex.tokens_in_record = '0;
        end
      end else if (c == CH_SEMI) begin
        lex.in_comment = 1'b1;
      end else if (c == CH_LPAREN) begin
        if (lex.nesting_depth >= DEPTH_CAP) t.error_code = ERR_DEPTH_OVERFLOW;
        else lex.nesting_depth++;
      end else if (c == CH_RPAREN) begin
        if (lex.nesting_depth == 0) t.error_code = ERR_STRAY_CLOSE;
        else lex.nesting_depth--;
      end else if (!blank_char(c)) begin
        t.is_content = 1'b1;
        t.token_start = 1'b1;
        t.token_index = lex.tokens_in_record;
        lex.in_token = 1'b1;
        lex.in_quoted = (c == CH_QUOTE);
        lex.escape_pending = 1'b0;
      end
    end

    t.paren_depth = lex.nesting_depth;

    // Close everything at the end of the file
    if (last) begin
      if (lex.in_token) begin
        if (lex.in_quoted && t.error_code == ERR_OK) t.error_code = ERR_EOF_OPEN;
        t.token_closed = 1'b1;
        t.token_index = lex.tokens_in_record;
        if (lex.tokens_in_record != TOK_MAX) lex.tokens_in_record++;
      end
      if (lex.nesting_depth != 0 && t.error_code == ERR_OK) t.error_code = ERR_EOF_OPEN;
      if (lex.tokens_in_record != 0) t.record_end = 1'b1;
      lex = '0;
    end
    return t;
  endfunction

  function void accept_byte(input logic [7:0] c, input logic last);
    pending_tags.push_back(tag_byte(c, last));
  endfunction

  function void compare_tag(input byte_tag_t got);
    byte_tag_t want;
    if (pending_tags.size() == 0) begin
      tag_errors++;
      if (tag_errors <= 10) $display("unexpected result: %s", show_tag(got));
      return;
    end
    want = pending_tags.pop_front();
    if (got !== want) begin
      tag_errors++;
      if (tag_errors <= 10) begin
        $display("mismatch expected: %s", show_tag(want));
        $display("         actual:   %s", show_tag(got));
      end
    end
  endfunction
endclass

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 130;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_byte_in   = '0;
  logic       in_last_byte = 1'b0;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte_out;
  logic       out_is_content;
  logic       out_token_start;
  logic       out_token_closed;
  logic [7:0] out_token_index;
  logic       out_record_end;
  logic [3:0] out_paren_depth;
  logic [2:0] out_error_code;

  // Handshake state sampled at the falling edge, used at the next rising edge
  logic       in_fire_s  = 1'b0;
  logic [7:0] in_byte_s  = '0;
  logic       in_last_s  = 1'b0;
  logic       out_fire_s = 1'b0;
  byte_tag_t  out_tag_s  = '0;

  tag_scoreboard sb;
  logic [7:0]    text_q[$];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            items_sent    = 0;
  int            quiet_cycles  = 0;

  zone_file_tokenizer_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_is_content   (out_is_content),
    .out_token_start  (out_token_start),
    .out_token_closed (out_token_closed),
    .out_token_index  (out_token_index),
    .out_record_end   (out_record_end),
    .out_paren_depth  (out_paren_depth),
    .out_error_code   (out_error_code)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Sample both channels mid-cycle, where everything has settled
  always @(negedge clk) begin
    in_fire_s  = (rst_n === 1'b1) && (in_valid === 1'b1) && (in_stall === 1'b0);
    in_byte_s  = in_byte_in;
    in_last_s  = in_last_byte;
    out_fire_s = (rst_n === 1'b1) && (out_valid === 1'b1) && (out_stall === 1'b0);
    out_tag_s.byte_out     = out_byte_out;
    out_tag_s.is_content   = out_is_content;
    out_tag_s.token_start  = out_token_start;
    out_tag_s.token_closed = out_token_closed;
    out_tag_s.token_index  = out_token_index;
    out_tag_s.record_end   = out_record_end;
    out_tag_s.paren_depth  = out_paren_depth;
    out_tag_s.error_code   = out_error_code;
  end

  // Predict each input transfer, then check each result transfer
  always @(posedge clk) begin
    if (in_fire_s) sb.accept_byte(in_byte_s, in_last_s);
    if (out_fire_s) sb.compare_tag(out_tag_s);
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if (in_fire_s || out_fire_s || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL zone_file_tokenizer_top");
    $finish;
  end

  // Present one byte, hold it until it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte_in   <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_fire_s) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_str(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(8'h61, 8'h7A));
      else c = 8'($urandom_range(0, 255));
    end while (word_break(c));
    return c;
  endfunction

  task automatic add_word();
    repeat ($urandom_range(1, 6)) text_q.push_back(word_char());
  endtask

  task automatic add_blank();
    repeat ($urandom_range(1, 2)) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic add_newline();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 1) text_q.push_back(CH_CR);
    if (pick == 2) text_q.push_back(CH_CR);
    else text_q.push_back(CH_LF);
  endtask

  // Quoted string with escapes; now and then a line break cuts it short
  task automatic add_quoted();
    logic [7:0] c;
    logic       cut;
    cut = 1'b0;
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      if (!cut) begin
        if ($urandom_range(0, 7) == 0) begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 39) == 0) begin
          text_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
          cut = 1'b1;
        end else begin
          do c = 8'($urandom_range(0, 255));
          while (line_break(c) || c == CH_QUOTE || c == CH_BSLASH);
          text_q.push_back(c);
        end
      end
    end
    if (!cut) text_q.push_back(CH_QUOTE);
  endtask

  task automatic add_comment();
    logic [7:0] c;
    text_q.push_back(CH_SEMI);
    repeat ($urandom_range(0, 5)) begin
      do c = 8'($urandom_range(0, 255));
      while (line_break(c));
      text_q.push_back(c);
    end
  endtask

  // Parenthesized group spanning lines, nested now and then
  task automatic add_group(input int lvl);
    int n;
    n = $urandom_range(1, 3);
    text_q.push_back(CH_LPAREN);
    for (int j = 0; j < n; j++) begin
      if (j > 0) begin
        if ($urandom_range(0, 1) != 0) add_blank();
        else add_newline();
      end
      if (lvl < 2 && $urandom_range(0, 4) == 0) add_group(lvl + 1);
      else if ($urandom_range(0, 3) == 0) add_quoted();
      else add_word();
    end
    text_q.push_back(CH_RPAREN);
  endtask

  // Nest up to and past the depth cap, sometimes with one close too many
  task automatic add_deep();
    int k;
    k = $urandom_range(14, 16);
    repeat (k) text_q.push_back(CH_LPAREN);
    add_word();
    repeat (k + $urandom_range(0, 1)) text_q.push_back(CH_RPAREN);
  endtask

  task automatic add_record();
    int n;
    int pick;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 10)) text_q.push_back(8'($urandom_range(0, 255)));
      add_newline();
      return;
    end
    n = $urandom_range(1, 5);
    if ($urandom_range(0, 4) == 0) add_blank();
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_blank();
      pick = $urandom_range(0, 99);
      if (pick < 50) add_word();
      else if (pick < 70) add_quoted();
      else if (pick < 85) add_group(0);
      else if (pick < 90) add_deep();
      else repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) add_comment();
    add_newline();
  endtask

  // A file of a few records, cut off at a random byte now and then
  task automatic build_file();
    int cut;
    repeat ($urandom_range(1, 4)) add_record();
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, text_q.size());
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
  endtask

  initial begin
    int phase_end;
    sb = new();
    send_idle_pct = 36;
    recv_idle_pct = 65;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stray close, byte extremes, escaped quote, line break inside a string,
    // nested groups spanning a line, CR LF pair, comment, end of file with open state
    send_str(")a", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_str(" \"\\\"\n(()b", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_str(")", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_str("\n;x\t\n", 1'b0);
    send_str("\"q", 1'b1);
    send_str("(", 1'b1);
    send_str("z", 1'b1);

    // Random files under three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 65;
        recv_idle_pct = 36;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        build_file();
        send_text();
      end
    end
    in_valid <= 1'b0;

    // Drain the results still owed
    while (sb.pending_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.tag_errors += sb.pending_tags.size();
    if (sb.tag_errors == 0) $display("PASS zone_file_tokenizer_top");
    else $display("FAIL zone_file_tokenizer_top");
    $finish;
  end

endmodule
